@@ rtl/lsps_pkg.sv @@
package lsps_pkg;

    // Input word opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One input word
    typedef struct packed {
        logic        op;
        logic [3:0]  task_slot;
        logic [15:0] first_release;
        logic [15:0] exec_time;
        logic [15:0] period;
    } in_item_t;

    // One result word
    typedef struct packed {
        logic               idle;
        logic [3:0]         chosen_slot;
        logic               job_started;
        logic               job_finished;
        logic               at_release;
        logic signed [31:0] chosen_slack;
        logic [31:0]        tick_time;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic tick_start;
        logic rd_en;
        logic commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ rtl/lsps_ctrl.sv @@
module lsps_ctrl
    import lsps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int SLOT_W    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    input  status_t           status,
    output cmd_t              cmd,
    output logic [SLOT_W-1:0] rd_addr
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FLUSH1 = 3'd2;
    localparam logic [2:0] ST_FLUSH2 = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [4:0]        task_count_reg;
    logic [CNT_W-1:0]  eff_count;
    logic              scan_last;

    // Clamp the slot count to the table depth
    always_comb begin
        if (int'(task_count_reg) > MAX_TASKS) begin
            eff_count = CNT_W'(MAX_TASKS);
        end else begin
            eff_count = CNT_W'(task_count_reg);
        end
    end

    assign scan_last = (CNT_W'(idx_reg) + CNT_W'(1)) == eff_count;
    assign cfg_ready = 1'b1;
    assign rd_addr   = idx_reg;

    // Hold the slot count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= 5'd0;
        end else if (cfg_valid && cfg_ready) begin
            task_count_reg <= cfg_data;
        end
    end

    // Sequence one word: load, or scan, flush, commit
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_TICK) begin
                        cmd.tick_start = 1'b1;
                        idx_next       = '0;
                        if (eff_count == '0) begin
                            state_next = ST_COMMIT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (scan_last) begin
                    state_next = ST_FLUSH1;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_FLUSH1: begin
                state_next = ST_FLUSH2;
            end
            ST_FLUSH2: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ rtl/lsps_datapath.sv @@
module lsps_datapath
    import lsps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32,
    parameter int SLOT_W    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  in_item_t          s_data,
    input  cmd_t              cmd,
    input  logic [SLOT_W-1:0] rd_addr,
    output status_t           status,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    localparam int SW = TIME_BITS + 2;

    // Task table
    logic [TIME_BITS-1:0] rel_mem [MAX_TASKS];
    logic [TIME_BITS-1:0] dl_mem  [MAX_TASKS];
    logic [15:0]          rem_mem [MAX_TASKS];
    logic [15:0]          exe_mem [MAX_TASKS];
    logic [15:0]          per_mem [MAX_TASKS];

    logic [MAX_TASKS-1:0] in_progress_reg;
    logic [TIME_BITS-1:0] now_reg;

    // Read stage
    logic                 rd_vld_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic [TIME_BITS-1:0] rel_rd_reg, dl_rd_reg;
    logic [15:0]          rem_rd_reg, exe_rd_reg, per_rd_reg;

    // Slack stage
    logic                 s1_vld_reg, s1_released_reg;
    logic [SLOT_W-1:0]    s1_idx_reg;
    logic signed [SW-1:0] s1_slack_reg;
    logic [TIME_BITS-1:0] s1_rel_reg, s1_dl_reg;
    logic [15:0]          s1_rem_reg, s1_exe_reg, s1_per_reg;

    // Best candidate so far
    logic                 found_reg;
    logic [SLOT_W-1:0]    best_idx_reg;
    logic signed [SW-1:0] best_slack_reg;
    logic [TIME_BITS-1:0] best_rel_reg, best_dl_reg;
    logic [15:0]          best_rem_reg, best_exe_reg, best_per_reg;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 load_ok, finished, take;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [TIME_BITS-1:0] wr_rel, wr_dl;
    logic [15:0]          wr_rem, wr_exe, wr_per;
    logic signed [SW-1:0] slack_calc;
    logic signed [63:0]   slack_wide;
    logic [31:0]          slack_sat;
    out_item_t            result;

    assign load_ok  = int'(s_data.task_slot) < MAX_TASKS;
    assign finished = best_rem_reg <= 16'd1;
    assign status.out_free = !out_valid_reg || m_ready;

    // Select the table write: a load or the chosen task's advance
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_rel  = best_rel_reg;
        wr_dl   = best_dl_reg;
        wr_rem  = best_rem_reg - 16'd1;
        wr_exe  = best_exe_reg;
        wr_per  = best_per_reg;
        if (cmd.load) begin
            wr_en   = load_ok;
            wr_addr = SLOT_W'(s_data.task_slot);
            wr_rel  = TIME_BITS'(s_data.first_release);
            wr_dl   = TIME_BITS'(s_data.first_release) + TIME_BITS'(s_data.period);
            wr_rem  = s_data.exec_time;
            wr_exe  = s_data.exec_time;
            wr_per  = s_data.period;
        end else if (cmd.commit) begin
            wr_en = found_reg;
            if (finished) begin
                wr_rel = best_rel_reg + TIME_BITS'(best_per_reg);
                wr_dl  = best_dl_reg + TIME_BITS'(best_per_reg);
                wr_rem = best_exe_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rel_mem[wr_addr] <= wr_rel;
            dl_mem[wr_addr]  <= wr_dl;
            rem_mem[wr_addr] <= wr_rem;
            exe_mem[wr_addr] <= wr_exe;
            per_mem[wr_addr] <= wr_per;
        end
    end

    // Read one slot per scan cycle
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rel_rd_reg <= rel_mem[rd_addr];
            dl_rd_reg  <= dl_mem[rd_addr];
            rem_rd_reg <= rem_mem[rd_addr];
            exe_rd_reg <= exe_mem[rd_addr];
            per_rd_reg <= per_mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    // Slack: deadline minus remaining minus now, exact
    assign slack_calc = SW'(dl_rd_reg) - SW'(rem_rd_reg) - SW'(now_reg);

    always_ff @(posedge aclk) begin
        s1_released_reg <= rel_rd_reg <= now_reg;
        s1_slack_reg    <= slack_calc;
        s1_idx_reg      <= rd_idx_reg;
        s1_rel_reg      <= rel_rd_reg;
        s1_dl_reg       <= dl_rd_reg;
        s1_rem_reg      <= rem_rd_reg;
        s1_exe_reg      <= exe_rd_reg;
        s1_per_reg      <= per_rd_reg;
    end

    // Keep the strictly smaller slack; ties stay with the lower slot
    assign take = s1_vld_reg && s1_released_reg &&
                  (!found_reg || (s1_slack_reg < best_slack_reg));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg   <= s1_idx_reg;
            best_slack_reg <= s1_slack_reg;
            best_rel_reg   <= s1_rel_reg;
            best_dl_reg    <= s1_dl_reg;
            best_rem_reg   <= s1_rem_reg;
            best_exe_reg   <= s1_exe_reg;
            best_per_reg   <= s1_per_reg;
        end
    end

    // Saturate the chosen slack to 32 bits
    assign slack_wide = 64'(best_slack_reg);
    always_comb begin
        if (slack_wide > 64'sd2147483647) begin
            slack_sat = 32'h7fff_ffff;
        end else if (slack_wide < -64'sd2147483648) begin
            slack_sat = 32'h8000_0000;
        end else begin
            slack_sat = slack_wide[31:0];
        end
    end

    // Build the result word
    always_comb begin
        result           = '0;
        result.idle      = !found_reg;
        result.tick_time = 32'(now_reg);
        if (found_reg) begin
            result.chosen_slot  = 4'(best_idx_reg);
            result.job_started  = !in_progress_reg[best_idx_reg];
            result.job_finished = finished;
            result.at_release   = now_reg == best_rel_reg;
            result.chosen_slack = slack_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= result;
        end
    end

    // Control state: pipeline valids, found flag, job flags, time, output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg      <= 1'b0;
            s1_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            in_progress_reg <= '0;
            now_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            s1_vld_reg <= rd_vld_reg;
            if (cmd.tick_start) begin
                found_reg <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.load && load_ok) begin
                in_progress_reg[SLOT_W'(s_data.task_slot)] <= 1'b0;
            end else if (cmd.commit && found_reg) begin
                in_progress_reg[best_idx_reg] <= !finished;
            end
            if (cmd.commit) begin
                now_reg       <= now_reg + TIME_BITS'(1);
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/least_slack_periodic_scheduler.sv @@
// Least-slack-first scheduler for periodic tasks.
// Input channel (s_valid/s_ready/s_data): a load word fills one task slot
// with first release, execution time and period; a tick word runs one time
// step and gives one result word on the m_ channel. Loads give no result.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number of
// slots that take part; write it only while the block is idle.
// A load is taken in the idle state. A tick scans N slots, N being the slot count
// clamped to MAX_TASKS: the task table has one read port and the scan
// reads one slot per cycle, then flushes the pipeline and commits.
// With no slots taking part the scan is skipped and the tick goes to commit.
// The result word waits in an output register; the next word is taken
// while it waits, but a tick does not commit until that register is free,
// so a stalled receiver holds the block in its commit cycle.
// Reset clears time, job-in-progress flags, the slot count and the output
// register; the table contents stay undefined until loaded. No clearing
// pass is needed after reset.
module least_slack_periodic_scheduler
    import lsps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    cmd_t              cmd;
    status_t           status;
    logic [SLOT_W-1:0] rd_addr;

    lsps_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .SLOT_W    (SLOT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_data.op),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    lsps_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS),
        .SLOT_W    (SLOT_W)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lsps_pkg::*;

    localparam int MAX_TASKS    = 16;
    localparam int TIME_BITS    = 32;
    localparam int DRAIN_CYCLES = 2 * (MAX_TASKS + 4);
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 14;
    localparam int PHASE_WORDS  = 42;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BEAT} rx_mode_t;

    typedef struct {
        bit         is_cfg;
        logic [4:0] cfg_val;
        in_item_t   word;
        bit         typed;
        out_item_t  exp;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    // Own copy of the scheduler state
    logic [4:0]           slot_count;
    logic [TIME_BITS-1:0] sched_now;
    logic [TIME_BITS-1:0] sched_release  [MAX_TASKS];
    logic [TIME_BITS-1:0] sched_deadline [MAX_TASKS];
    logic [15:0]          sched_left     [MAX_TASKS];
    logic [15:0]          sched_exec     [MAX_TASKS];
    logic [15:0]          sched_period   [MAX_TASKS];
    logic                 sched_busy     [MAX_TASKS];

    out_item_t   tick_reports_q[$];
    int unsigned err_count;
    int unsigned n_checked, n_loads, n_idle, n_done, n_cfg;

    // Sender and receiver control
    bit          use_typed;
    out_item_t   typed_word;
    bit          gaps_on;
    int unsigned burst_left;
    int unsigned stim_ticks;
    int unsigned hold_asks, hold_done;

    least_slack_periodic_scheduler #(
        .MAX_TASKS(MAX_TASKS),
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Advance the scheduler by one word; returns 1 when a tick report is due
    function automatic bit next_schedule(input in_item_t w, output out_item_t r);
        int unsigned n;
        bit          found;
        logic [3:0]  best;
        longint      best_slack;
        longint      s;
        r = '0;
        if (w.op == OP_LOAD) begin
            sched_release[w.task_slot]  = {16'd0, w.first_release};
            sched_deadline[w.task_slot] = {16'd0, w.first_release} + {16'd0, w.period};
            sched_left[w.task_slot]     = w.exec_time;
            sched_exec[w.task_slot]     = w.exec_time;
            sched_period[w.task_slot]   = w.period;
            sched_busy[w.task_slot]     = 1'b0;
            return 1'b0;
        end
        n = (slot_count > MAX_TASKS) ? MAX_TASKS : slot_count;
        found = 1'b0;
        best = '0;
        best_slack = 0;
        // scan released slots for the least slack, lowest slot wins a tie
        for (int i = 0; i < n; i++) begin
            if (sched_release[i] <= sched_now) begin
                s = longint'({32'd0, sched_deadline[i]}) - longint'({48'd0, sched_left[i]})
                    - longint'({32'd0, sched_now});
                if (!found || s < best_slack) begin
                    found = 1'b1;
                    best = 4'(i);
                    best_slack = s;
                end
            end
        end
        r.idle = !found;
        r.tick_time = sched_now[31:0];
        if (found) begin
            r.chosen_slot = best;
            r.job_started = !sched_busy[best];
            r.at_release  = (sched_now == sched_release[best]);
            if (best_slack > 64'sd2147483647)
                r.chosen_slack = 32'sh7fffffff;
            else if (best_slack < -64'sd2147483648)
                r.chosen_slack = 32'sh80000000;
            else
                r.chosen_slack = best_slack[31:0];
            sched_busy[best] = 1'b1;
            // retire the job and move on to the next period
            if (sched_left[best] <= 16'd1) begin
                r.job_finished = 1'b1;
                sched_release[best]  = sched_release[best] + sched_period[best];
                sched_deadline[best] = sched_deadline[best] + sched_period[best];
                sched_left[best]     = sched_exec[best];
                sched_busy[best]     = 1'b0;
            end else begin
                sched_left[best] = sched_left[best] - 16'd1;
            end
        end
        sched_now = sched_now + 1'b1;
        return 1'b1;
    endfunction

    task automatic show_word(input string tag, input out_item_t w);
        $display("%s idle=%0d slot=%0d start=%0d done=%0d at_rel=%0d slack=%0d time=%0d",
                 tag, w.idle, w.chosen_slot, w.job_started, w.job_finished,
                 w.at_release, w.chosen_slack, w.tick_time);
    endtask

    // Check result words, then predict from accepted input words
    always @(posedge aclk) begin : check_and_predict
        string     bad;
        out_item_t want;
        out_item_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (tick_reports_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        show_word("unexpected result word:", m_data);
                end else begin
                    want = tick_reports_q.pop_front();
                    bad = "";
                    if (m_data.idle !== want.idle)                 bad = {bad, " idle"};
                    if (m_data.chosen_slot !== want.chosen_slot)   bad = {bad, " chosen_slot"};
                    if (m_data.job_started !== want.job_started)   bad = {bad, " job_started"};
                    if (m_data.job_finished !== want.job_finished) bad = {bad, " job_finished"};
                    if (m_data.at_release !== want.at_release)     bad = {bad, " at_release"};
                    if (m_data.chosen_slack !== want.chosen_slack) bad = {bad, " chosen_slack"};
                    if (m_data.tick_time !== want.tick_time)       bad = {bad, " tick_time"};
                    if (bad != "") begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("tick report %0d: mismatch in%s", n_checked, bad);
                            show_word("  expected:", want);
                            show_word("  actual:  ", m_data);
                        end
                    end
                    n_checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (next_schedule(s_data, pred)) begin
                    tick_reports_q.push_back(use_typed ? typed_word : pred);
                    if (pred.idle) n_idle++;
                    if (pred.job_finished) n_done++;
                end else begin
                    n_loads++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                slot_count = cfg_data;
                n_cfg++;
            end
        end
    end

    // Receiver: stall on its own pattern, with a long hold-off on request
    initial begin : receiver
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned beat;
        m_ready = 1'b0;
        rx_mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        beat = 0;
        forever begin
            @(negedge aclk);
            beat++;
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_asks != hold_done) begin
                hold_done++;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (beat % 5 < 2);
                endcase
            end
        end
    end

    // Drop valid for a number of cycles
    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(input in_item_t w, input bit typed, input out_item_t exp);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        use_typed = typed;
        typed_word = exp;
        if (w.op == OP_TICK) stim_ticks++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send in bursts, with random gaps between them while gaps_on is set
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) idle_cycles($urandom_range(1, 8));
        end
        burst_left--;
    endtask

    // Hold off until every tick report has come and the block has settled
    task automatic drain_reports();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tick_reports_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slot_count(input logic [4:0] v);
        drain_reports();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_tick();
        in_item_t w;
        w.op            = OP_TICK;
        w.task_slot     = 4'($urandom);
        w.first_release = 16'($urandom);
        w.exec_time     = 16'($urandom);
        w.period        = 16'($urandom);
        return w;
    endfunction

    // Mostly small tasks near the current time; some full-range noise
    function automatic in_item_t random_task_load(input int unsigned t_now);
        in_item_t    w;
        int unsigned pick;
        w.op = OP_LOAD;
        w.task_slot = 4'($urandom);
        w.first_release = 16'(t_now + $urandom_range(0, 10));
        w.exec_time = 16'($urandom_range(1, 6));
        w.period = w.exec_time + 16'($urandom_range(0, 14));
        pick = $urandom_range(0, 15);
        if (pick < 2) begin
            w.first_release = 16'($urandom);
            w.exec_time     = 16'($urandom);
            w.period        = 16'($urandom);
        end else if (pick == 2) begin
            if ($urandom_range(0, 1)) w.exec_time = '0;
            else w.period = '0;
        end else if (pick == 3) begin
            // late release: deadline already close or missed
            w.first_release = (t_now > 20) ? 16'(t_now - $urandom_range(0, 20)) : '0;
            w.exec_time = 16'($urandom_range(4, 12));
        end else if (pick == 4) begin
            w.exec_time = w.period + 16'($urandom_range(1, 5));
        end
        return w;
    endfunction

    function automatic stim_row_t row_load(input logic [3:0] slot, input logic [15:0] rel,
                                          input logic [15:0] ex, input logic [15:0] per);
        stim_row_t r;
        r = '{default: '0};
        r.word.op = OP_LOAD;
        r.word.task_slot = slot;
        r.word.first_release = rel;
        r.word.exec_time = ex;
        r.word.period = per;
        return r;
    endfunction

    function automatic stim_row_t row_tick();
        stim_row_t r;
        r = '{default: '0};
        r.word.op = OP_TICK;
        return r;
    endfunction

    function automatic stim_row_t row_idle_tick(input logic [31:0] t);
        stim_row_t r;
        r = row_tick();
        r.typed = 1'b1;
        r.exp.idle = 1'b1;
        r.exp.tick_time = t;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input logic [4:0] v);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    initial begin : stimulus
        stim_row_t   dir_rows[$];
        int          phase_counts[12];
        int          left;
        int unsigned nl, nt;
        bit          paused;
        logic [4:0]  cnt;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        use_typed = 1'b0;
        typed_word = '0;
        gaps_on = 1'b1;
        burst_left = 0;
        stim_ticks = 0;
        hold_asks = 0;
        hold_done = 0;
        err_count = 0;
        n_checked = 0;
        n_loads = 0;
        n_idle = 0;
        n_done = 0;
        n_cfg = 0;
        slot_count = '0;
        sched_now = '0;
        foreach (sched_busy[i]) sched_busy[i] = 1'b0;
        paused = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: no slots after reset, then extremes, zero exec and period, reloads
        dir_rows.push_back(row_idle_tick(32'd0));
        dir_rows.push_back(row_idle_tick(32'd1));
        dir_rows.push_back(row_load(4'd0, 16'd0, 16'd0, 16'd0));
        dir_rows.push_back(row_load(4'd1, 16'hffff, 16'hffff, 16'hffff));
        dir_rows.push_back(row_load(4'd2, 16'd2, 16'd3, 16'd5));
        dir_rows.push_back(row_load(4'd3, 16'd0, 16'd2, 16'd4));
        dir_rows.push_back(row_cfg(5'd4));
        repeat (3) dir_rows.push_back(row_tick());
        dir_rows.push_back(row_load(4'd0, 16'd7, 16'd1, 16'd3));
        repeat (6) dir_rows.push_back(row_tick());
        dir_rows.push_back(row_load(4'd3, 16'd0, 16'd9, 16'd9));
        repeat (3) dir_rows.push_back(row_tick());
        dir_rows.push_back(row_cfg(5'd0));
        dir_rows.push_back(row_tick());
        dir_rows.push_back(row_cfg(5'd2));
        repeat (2) dir_rows.push_back(row_tick());

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_slot_count(dir_rows[i].cfg_val);
            end else begin
                pace();
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].exp);
            end
        end

        // Fill every slot so that any slot count reads loaded entries only
        for (int i = 0; i < MAX_TASKS; i++) begin
            in_item_t w;
            w = random_task_load(stim_ticks);
            w.task_slot = 4'(i);
            pace();
            send_word(w, 1'b0, '0);
        end

        // Random phases: loads followed by runs of ticks, one slot count per phase
        phase_counts = '{16, 31, 1, 0, 16, 17, 5, 12, 3, 24, 2, 8};
        for (int ph = 0; ph < PHASES; ph++) begin
            cnt = (ph < 12) ? 5'(phase_counts[ph]) : 5'($urandom_range(0, 31));
            write_slot_count(cnt);
            gaps_on = (ph % 3 != 2);
            if (ph == 4) begin
                // stall the receiver and keep offering ticks until the input backs up
                @(posedge aclk);
                hold_asks++;
                repeat (30) send_word(random_tick(), 1'b0, '0);
            end
            left = PHASE_WORDS;
            while (left > 0) begin
                nl = $urandom_range(0, 3);
                nt = $urandom_range(2, 14);
                repeat (nl) begin
                    pace();
                    send_word(random_task_load(stim_ticks), 1'b0, '0);
                end
                repeat (nt) begin
                    pace();
                    send_word(random_tick(), 1'b0, '0);
                end
                left -= int'(nl + nt);
                if (ph == 8 && !paused && left < PHASE_WORDS / 2) begin
                    drain_reports();
                    paused = 1'b1;
                end
            end
        end

        drain_reports();
        $display("Covered %0d task loads, %0d tick reports (%0d idle, %0d job completions)",
                 n_loads, n_checked, n_idle, n_done);
        $display("across %0d slot-count writes; %0d mismatches", n_cfg, err_count);
        if (err_count == 0 && tick_reports_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
